FILE: sv/assert_macros.svh
// assertion macros used by srmc_back
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRMC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("assertion failed");
`define SRMC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define SRMC_ASSERT(label, prop)
`define SRMC_ASSERT_RST(label, prop)
`endif
`endif

FILE: sv/srmc_pkg.sv
// shared types and constants of the send/receive match checker
// no dependencies
package srmc_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned TimeDepth    = 8;
  localparam int unsigned CountBits    = 16;
  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned HeadW = (TimeDepth > 1) ? $clog2(TimeDepth) : 1;
  localparam int unsigned XcW   = $clog2(TimeDepth + 1);
  localparam int unsigned NumW  = $clog2(TableEntries + 1);

  typedef enum logic [2:0] {
    ST_SEND_QUEUED  = 3'd0,
    ST_LATE_SEND    = 3'd1,
    ST_RECV_MATCHED = 3'd2,
    ST_RECV_EXPECT  = 3'd3,
    ST_RECV_DROPPED = 3'd4,
    ST_TABLE_FULL   = 3'd5,
    ST_TIME_FULL    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_RESULT
  } back_state_e;

  typedef struct packed {
    logic        command;
    logic [31:0] source_process;
    logic [31:0] dest_process;
    logic [31:0] communicator;
    logic [31:0] msg_tag;
    logic [63:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] delay;
    logic [31:0] early_recv_total;
    logic [31:0] late_send_total;
    logic [6:0]  keys_with_sends;
    logic [6:0]  keys_with_expected;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic            is_recv;
    logic            hit;
    logic            free_ok;
    logic [IdxW-1:0] idx;
    logic [63:0]     procs;
    logic [63:0]     ct;
    logic [63:0]     ts;
  } task_t;

endpackage

FILE: sv/send_receive_match_checker.sv
// top level of the send/receive match checker
// depends on srmc_pkg, srmc_front, srmc_back
//
//  channel  direction  handshake                    payload
//  in       input      in_valid_i / in_ready_o      in_data_i  (in_item_t)
//  out      output     out_valid_o / out_ready_i    out_data_o (out_item_t)
//  cfg      input      lost_send_mode_we_i          lost_send_mode_i
//
// each item passes through lookup and queue, hand-off to the back end with
// a registered read of the entry counts, read of the timestamp memory, commit
// into the result register; the table is free for the next lookup only after
// the commit, so items are handled one at a time
// reset clears valid bits and counters at once, no clearing pass
// a result waiting in the output register holds the commit step, and the
// input waits behind it
module send_receive_match_checker import srmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      lost_send_mode_we_i,
  input  logic      lost_send_mode_i
);

  logic mode_q;
  logic task_valid, task_ready, busy;
  task_t task_w;
  logic [TableEntries-1:0] ent_valid;
  logic [63:0] ent_procs [TableEntries];
  logic [63:0] ent_ct [TableEntries];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (lost_send_mode_we_i) begin
      mode_q <= lost_send_mode_i;
    end
  end

  srmc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .ent_valid_i(ent_valid), .ent_procs_i(ent_procs), .ent_ct_i(ent_ct),
    .busy_i(busy), .task_valid_o(task_valid), .task_ready_i(task_ready),
    .task_o(task_w)
  );

  srmc_back u_back (
    .clk_i, .rst_ni, .lost_send_mode_i(mode_q),
    .task_valid_i(task_valid), .task_ready_o(task_ready), .task_i(task_w),
    .busy_o(busy), .ent_valid_o(ent_valid), .ent_procs_o(ent_procs),
    .ent_ct_o(ent_ct), .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

FILE: sv/srmc_front.sv
// front end: key lookup over the entry table, one classified task per item
// depends on srmc_pkg
module srmc_front import srmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_item_t                in_data_i,
  input  logic [TableEntries-1:0] ent_valid_i,
  input  logic [63:0]             ent_procs_i [TableEntries],
  input  logic [63:0]             ent_ct_i [TableEntries],
  input  logic                    busy_i,
  output logic                    task_valid_o,
  input  logic                    task_ready_i,
  output task_t                   task_o
);

  logic [63:0] procs, ct;
  logic [TableEntries-1:0] hit_vec;
  logic hit, free_ok;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic full_q, full_d;
  task_t task_q, task_d;

  assign procs = {in_data_i.source_process, in_data_i.dest_process};
  assign ct    = {in_data_i.communicator, in_data_i.msg_tag};

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      hit_vec[i] = ent_valid_i[i] && ent_procs_i[i] == procs && ent_ct_i[i] == ct;
    end
  end

  always_comb begin
    hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit = 1'b1; hit_idx = IdxW'(i);
      end
      if (!ent_valid_i[i]) begin
        free_ok = 1'b1; free_idx = IdxW'(i);
      end
    end
  end

  // one-entry queue; table lookup only while the back end has no item in flight
  assign in_ready_o = !full_q && !busy_i;

  always_comb begin
    task_d.is_recv = in_data_i.command;
    task_d.hit     = hit;
    task_d.free_ok = free_ok;
    task_d.idx     = hit ? hit_idx : free_idx;
    task_d.procs   = procs;
    task_d.ct      = ct;
    task_d.ts      = in_data_i.timestamp;
    full_d = full_q;
    if (task_valid_o && task_ready_i) full_d = 1'b0;
    if (in_valid_i && in_ready_o) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) task_q <= task_d;
  end

  assign task_valid_o = full_q;
  assign task_o       = task_q;

endmodule

FILE: sv/srmc_back.sv
// back end: entry table, timestamp memory, counters and result register
// depends on srmc_pkg and assert_macros.svh
`include "assert_macros.svh"
module srmc_back import srmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    lost_send_mode_i,
  input  logic                    task_valid_i,
  output logic                    task_ready_o,
  input  task_t                   task_i,
  output logic                    busy_o,
  output logic [TableEntries-1:0] ent_valid_o,
  output logic [63:0]             ent_procs_o [TableEntries],
  output logic [63:0]             ent_ct_o [TableEntries],
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_item_t               out_data_o
);

  localparam logic [CountBits-1:0] SendMax = '1;

  back_state_e state_q, state_d;
  task_t t_q;
  logic [TableEntries-1:0] valid_q;
  logic [63:0] procs_q [TableEntries];
  logic [63:0] ct_q [TableEntries];
  logic [CountBits-1:0] sends_q [TableEntries];
  logic [XcW-1:0] xc_q [TableEntries];
  logic [HeadW-1:0] head_q [TableEntries];
  logic [63:0] times_mem [TableEntries * TimeDepth];
  logic [63:0] early_rd_q;
  logic [CountBits-1:0] s_rd_q;
  logic [XcW-1:0] x_rd_q;
  logic [HeadW-1:0] h_rd_q;
  logic [31:0] early_cnt_q, late_cnt_q;
  logic [NumW-1:0] ns_q, nx_q;
  logic out_valid_q;
  out_item_t out_q;

  // current entry view; a fresh entry reads as empty
  logic [CountBits-1:0] cur_s;
  logic [XcW-1:0] cur_x;
  logic [HeadW-1:0] cur_h;
  logic [IdxW+HeadW-1:0] rd_addr, wr_addr;
  logic [HeadW:0] tail_sum, tail_wrap;

  assign cur_s = t_q.hit ? s_rd_q : '0;
  assign cur_x = t_q.hit ? x_rd_q : '0;
  assign cur_h = t_q.hit ? h_rd_q : '0;
  assign tail_sum = (HeadW+1)'(cur_h) + (HeadW+1)'(cur_x);
  assign tail_wrap = (tail_sum >= (HeadW+1)'(TimeDepth)) ?
                     tail_sum - (HeadW+1)'(TimeDepth) : tail_sum;
  assign rd_addr = (IdxW+HeadW)'(t_q.idx) * (IdxW+HeadW)'(TimeDepth) + (IdxW+HeadW)'(cur_h);
  assign wr_addr = (IdxW+HeadW)'(t_q.idx) * (IdxW+HeadW)'(TimeDepth)
                 + (IdxW+HeadW)'(tail_wrap);

  // decision
  logic [2:0] st;
  logic do_late, do_send, do_rmatch, do_expect, alloc;
  always_comb begin
    do_late = 0; do_send = 0; do_rmatch = 0; do_expect = 0; alloc = 0;
    st = ST_TABLE_FULL;
    if (!t_q.is_recv) begin
      if (t_q.hit && cur_x != '0) begin
        do_late = 1; st = ST_LATE_SEND;
      end else if (t_q.hit || t_q.free_ok) begin
        do_send = 1; alloc = !t_q.hit; st = ST_SEND_QUEUED;
      end
    end else begin
      if (t_q.hit && cur_s != '0) begin
        do_rmatch = 1; st = ST_RECV_MATCHED;
      end else if (lost_send_mode_i) begin
        st = ST_RECV_DROPPED;
      end else if (!(t_q.hit || t_q.free_ok)) begin
        st = ST_TABLE_FULL;
      end else if (cur_x >= XcW'(TimeDepth)) begin
        st = ST_TIME_FULL;
      end else begin
        do_expect = 1; alloc = !t_q.hit; st = ST_RECV_EXPECT;
      end
    end
  end

  logic [CountBits-1:0] new_s;
  logic [XcW-1:0] new_x;
  logic [HeadW-1:0] new_h;
  logic new_v, act;
  always_comb begin
    new_s = cur_s; new_x = cur_x; new_h = cur_h;
    if (do_late) begin
      new_x = cur_x - 1'b1;
      new_h = (cur_h == HeadW'(TimeDepth - 1)) ? '0 : cur_h + 1'b1;
    end
    if (do_send && cur_s != SendMax) new_s = cur_s + 1'b1;
    if (do_rmatch) new_s = cur_s - 1'b1;
    if (do_expect) new_x = cur_x + 1'b1;
    new_v = (new_s != '0) || (new_x != '0);
    act = do_late || do_send || do_rmatch || do_expect;
  end

  // running key counts, updated by deltas of the one touched entry
  logic old_sn, old_xn, nw_sn, nw_xn;
  logic [NumW-1:0] ns_d, nx_d;
  always_comb begin
    old_sn = t_q.hit && cur_s != '0;
    old_xn = t_q.hit && cur_x != '0;
    nw_sn  = new_s != '0;
    nw_xn  = new_x != '0;
    ns_d = ns_q; nx_d = nx_q;
    if (act) begin
      ns_d = ns_q + NumW'(nw_sn) - NumW'(old_sn);
      nx_d = nx_q + NumW'(nw_xn) - NumW'(old_xn);
    end
  end

  logic [31:0] early_d, late_d;
  assign early_d = (do_expect && early_cnt_q != '1) ? early_cnt_q + 1 : early_cnt_q;
  assign late_d  = (do_late && late_cnt_q != '1) ? late_cnt_q + 1 : late_cnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (task_valid_i) state_d = BK_READ;
      BK_READ:   state_d = BK_RESULT;
      BK_RESULT: if (!out_valid_q || out_ready_i) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  logic commit;
  always_comb begin
    task_ready_o = (state_q == BK_IDLE);
    commit       = (state_q == BK_RESULT) && (!out_valid_q || out_ready_i);
    busy_o       = (state_q != BK_IDLE) || task_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= '0;
      early_cnt_q <= '0;
      late_cnt_q <= '0;
      ns_q <= '0;
      nx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= commit || (out_valid_q && !out_ready_i);
      if (commit) begin
        if (act) valid_q[t_q.idx] <= new_v;
        early_cnt_q <= early_d;
        late_cnt_q <= late_d;
        ns_q <= ns_d;
        nx_q <= nx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // registered read of the entry counts as the task is taken
    if (task_valid_i && task_ready_o) begin
      t_q <= task_i;
      s_rd_q <= sends_q[task_i.idx];
      x_rd_q <= xc_q[task_i.idx];
      h_rd_q <= head_q[task_i.idx];
    end
    if (state_q == BK_READ) early_rd_q <= times_mem[rd_addr];
    if (commit) begin
      if (act) begin
        sends_q[t_q.idx] <= new_s;
        xc_q[t_q.idx] <= new_x;
        head_q[t_q.idx] <= new_h;
      end
      if (alloc) begin
        procs_q[t_q.idx] <= t_q.procs;
        ct_q[t_q.idx] <= t_q.ct;
      end
      if (do_expect) times_mem[wr_addr] <= t_q.ts;
      out_q.status <= st;
      out_q.delay <= do_late ? t_q.ts - early_rd_q : '0;
      out_q.early_recv_total <= early_d;
      out_q.late_send_total <= late_d;
      out_q.keys_with_sends <= 7'(ns_d);
      out_q.keys_with_expected <= 7'(nx_d);
    end
  end

  assign ent_valid_o = valid_q;
  assign ent_procs_o = procs_q;
  assign ent_ct_o    = ct_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SRMC_ASSERT(a_commit_from_result, commit |-> state_q == BK_RESULT)
  `SRMC_ASSERT(a_late_needs_hit, (commit && do_late) |-> t_q.hit)
  `SRMC_ASSERT(a_counts_bounded, ns_q <= NumW'(TableEntries) && nx_q <= NumW'(TableEntries))
  `SRMC_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_q || rst_ni)

endmodule
